>>> hw/rtl/crcsr_pkg.sv
// ----------------------------------------------------------------------------
// crcsr_pkg
// Shared types, codes and helper functions of the CRC64 sponge generator.
// ----------------------------------------------------------------------------
`default_nettype none

package crcsr_pkg;

   localparam logic [63:0] POLY_RESET    = 64'h42f0e1eba9ea3693;
   localparam logic [63:0] INIT_CRC_RESET = 64'hffffffffffffffff;
   localparam logic [63:0] XOR_OUT_RESET = 64'hffffffffffffffff;
   localparam logic [7:0]  ABS_RND_RESET = 8'd8;
   localparam logic [7:0]  SQZ_RND_RESET = 8'd1;

   // Request operation codes.
   localparam logic [2:0] OP_ABSORB  = 3'd0;
   localparam logic [2:0] OP_FINAL   = 3'd1;
   localparam logic [2:0] OP_READ    = 3'd2;
   localparam logic [2:0] OP_LOAD    = 3'd3;
   localparam logic [2:0] OP_RESTORE = 3'd4;

   // Register indexes.
   localparam logic [2:0] REG_POLY    = 3'd0;
   localparam logic [2:0] REG_INIT    = 3'd1;
   localparam logic [2:0] REG_XOR_OUT = 3'd2;
   localparam logic [2:0] REG_ABS_RND = 3'd3;
   localparam logic [2:0] REG_SQZ_RND = 3'd4;

   typedef logic [7:0][63:0] basis_type;

   typedef struct packed {
      logic poly_load;
      logic crc_load;
      logic step;
   } crc_ctl_type;

   typedef struct packed {
      logic rec_en;
      logic shift;
   } xp_ctl_type;

   // The byte table is linear over GF(2): entry v is the XOR of the
   // entries of the single bits set in v, so only those eight are kept.
   function automatic basis_type build_basis(input logic [63:0] poly);
      basis_type  b;
      logic [63:0] t;
      for (int k = 0; k < 8; k++) begin
         t = 64'h1 << (56 + k);
         for (int s = 0; s < 8; s++) begin
            t = {t[62:0], 1'b0} ^ (t[63] ? poly : 64'h0);
         end
         b[k] = t;
      end
      return b;
   endfunction

   // Eight byte steps of the CRC, least significant byte of the word first.
   function automatic logic [63:0] crc_word(input logic [63:0] crc,
                                            input logic [63:0] word,
                                            input basis_type b);
      logic [63:0] c;
      logic [63:0] t;
      logic [7:0]  ix;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         ix = c[7:0] ^ word[8*k +: 8];
         t  = 64'h0;
         for (int n = 0; n < 8; n++) begin
            t = t ^ (ix[n] ? b[n] : 64'h0);
         end
         c = t ^ {8'h00, c[63:8]};
      end
      return c;
   endfunction

   function automatic logic [63:0] diag_mask(input logic [5:0] i);
      return (64'h8000000000000000 >> i) | (64'h1 << i);
   endfunction

   function automatic logic [63:0] pad_block(input logic [63:0] data,
                                             input logic [2:0]  cnt);
      logic [63:0] blk;
      blk = 64'h0;
      case (cnt)
         3'd0:    blk = 64'h8000000000000001;
         3'd1:    blk = {data[7:0],  8'h80, 48'h0} | 64'h1;
         3'd2:    blk = {data[15:0], 8'h80, 40'h0} | 64'h1;
         3'd3:    blk = {data[23:0], 8'h80, 32'h0} | 64'h1;
         3'd4:    blk = {data[31:0], 8'h80, 24'h0} | 64'h1;
         3'd5:    blk = {data[39:0], 8'h80, 16'h0} | 64'h1;
         3'd6:    blk = {data[47:0], 8'h80, 8'h0}  | 64'h1;
         3'd7:    blk = {data[55:0], 8'h81};
         default: blk = 64'h0;
      endcase
      return blk;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crcsr_crc.sv
// ----------------------------------------------------------------------------
// crcsr_crc
// Running CRC64 register and byte-table basis; folds one word per cycle while step is set.
// ----------------------------------------------------------------------------
`default_nettype none

module crcsr_crc (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crcsr_pkg::crc_ctl_type ctl,
   input  wire logic [63:0]           value,
   input  wire logic [63:0]           word,
   output logic [63:0]                crc_nx
);

   crcsr_pkg::basis_type basis_ff, basis_in;
   logic [63:0]          crc_ff, crc_in;

   assign crc_nx = crcsr_pkg::crc_word(crc_ff, word, basis_ff);

   always_comb begin
      basis_in = basis_ff;
      crc_in   = crc_ff;
      if (ctl.poly_load) begin
         basis_in = crcsr_pkg::build_basis(value);
      end
      if (ctl.crc_load) begin
         crc_in = value;
      end else if (ctl.step) begin
         crc_in = crc_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         basis_ff <= crcsr_pkg::build_basis(crcsr_pkg::POLY_RESET);
         crc_ff   <= crcsr_pkg::INIT_CRC_RESET;
      end else begin
         basis_ff <= basis_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/crcsr_xpose.sv
// ----------------------------------------------------------------------------
// crcsr_xpose
// Holds the 64 words recorded in a round and hands them out transposed.
// ----------------------------------------------------------------------------
`default_nettype none

module crcsr_xpose (
   input  wire logic                 clock,
   input  wire crcsr_pkg::xp_ctl_type ctl,
   input  wire logic [5:0]           rec_idx,
   input  wire logic [63:0]          rec_data,
   output logic [63:0]               word
);

   logic [63:0] cols_ff [64];

   // Each shift moves the next bit of every record to its top, so the
   // top bits together form the next transposed word.
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         word[63 - i] = cols_ff[i][63];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 64; i++) begin
         if (ctl.rec_en && (rec_idx == 6'(i))) begin
            cols_ff[i] <= rec_data;
         end else if (ctl.shift) begin
            cols_ff[i] <= {cols_ff[i][62:0], 1'b0};
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/crc64_sponge_rng.sv
// ----------------------------------------------------------------------------
// crc64_sponge_rng
// Sponge random generator over 64 words of 64 bits mixed by a running CRC64.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req_    | in        | tuser: operation; tdata: block_data, byte_count, word_index
//  rsp_    | out       | tdata: random_byte
//  csr_    | in        | csr_index, csr_wdata
//
//  A round folds the state words through the CRC, one word per cycle from
//  the state memory, and then writes back the transposed records. An absorb
//  merges its block and runs absorb_rounds rounds; a read that squeezes
//  gathers the output word and runs squeeze_rounds rounds before its byte;
//  a read from the held word only emits its byte; a restore copies the
//  initial words and a load writes one initial word without leaving idle.
//  Reset is synchronous; the state memory holds no defined value until a
//  restore. A read waits in its last cycle while an earlier byte is held.
// ----------------------------------------------------------------------------
`default_nettype none

module crc64_sponge_rng (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // block_data[63:0], byte_count[66:64],
                                        // word_index[72:67], zero fill
   input  wire logic [2:0]  req_tuser,  // operation[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // random_byte[7:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MERGE  = 3'd1;
   localparam logic [2:0] S_SQZ    = 3'd2;
   localparam logic [2:0] S_RCRC   = 3'd3;
   localparam logic [2:0] S_RXPOSE = 3'd4;
   localparam logic [2:0] S_COPY   = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        pend_ff, pend_in;
   logic [5:0]  paddr_ff, paddr_in;
   logic [7:0]  rounds_ff, rounds_in;
   logic        sq_ff, sq_in;
   logic [63:0] block_ff, block_in;
   logic [63:0] diag_ff, diag_in;
   logic [63:0] buf_ff, buf_in;
   logic [3:0]  bl_ff, bl_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic [63:0] xor_out_ff;
   logic [7:0]  abs_rnd_ff, sqz_rnd_ff;

   logic [63:0] sponge_mem [64];
   logic [63:0] init_mem [64];
   logic [63:0] sp_rdata_ff, in_rdata_ff;
   logic        sp_we, in_we;
   logic [5:0]  sp_waddr, sp_raddr, in_raddr;
   logic [63:0] sp_wdata;

   crcsr_pkg::crc_ctl_type crc_ctl;
   crcsr_pkg::xp_ctl_type  xp_ctl;
   logic [63:0]            crc_nx, xword, diag_nx;
   logic [2:0]             finish;
   logic [2:0]             bsel;
   logic                   req_fire, csr_fire;

   logic [2:0]  f_op;
   logic [63:0] f_data;
   logic [2:0]  f_cnt;
   logic [5:0]  f_idx;

   assign f_op   = req_tuser;
   assign f_data = req_tdata[63:0];
   assign f_cnt  = req_tdata[66:64];
   assign f_idx  = req_tdata[72:67];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign finish  = sq_ff ? S_EMIT : S_IDLE;
   assign diag_nx = pend_ff ? (diag_ff | (sp_rdata_ff & crcsr_pkg::diag_mask(paddr_ff)))
                            : diag_ff;
   assign bsel    = 3'(4'd8 - bl_ff);

   crcsr_crc u_crc (
      .clock  (clock),
      .reset  (reset),
      .ctl    (crc_ctl),
      .value  (csr_wdata),
      .word   (sp_rdata_ff),
      .crc_nx (crc_nx)
   );

   crcsr_xpose u_xpose (
      .clock    (clock),
      .ctl      (xp_ctl),
      .rec_idx  (paddr_ff),
      .rec_data (crc_nx ^ xor_out_ff),
      .word     (xword)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      paddr_in     = paddr_ff;
      rounds_in    = rounds_ff;
      sq_in        = sq_ff;
      block_in     = block_ff;
      diag_in      = diag_ff;
      buf_in       = buf_ff;
      bl_in        = bl_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      sp_we        = 1'b0;
      sp_waddr     = paddr_ff;
      sp_wdata     = sp_rdata_ff;
      sp_raddr     = cnt_ff[5:0];
      in_we        = 1'b0;
      in_raddr     = cnt_ff[5:0];
      crc_ctl.poly_load = csr_fire && (csr_index == crcsr_pkg::REG_POLY);
      crc_ctl.crc_load  = csr_fire && (csr_index == crcsr_pkg::REG_INIT);
      crc_ctl.step      = 1'b0;
      xp_ctl.rec_en     = 1'b0;
      xp_ctl.shift      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cnt_in = 7'd0;
               case (f_op)
                  crcsr_pkg::OP_ABSORB: begin
                     block_in = f_data;
                     sq_in    = 1'b0;
                     state_in = S_MERGE;
                  end
                  crcsr_pkg::OP_FINAL: begin
                     block_in = crcsr_pkg::pad_block(f_data, f_cnt);
                     sq_in    = 1'b0;
                     state_in = S_MERGE;
                  end
                  crcsr_pkg::OP_READ: begin
                     diag_in  = 64'h0;
                     sq_in    = 1'b1;
                     state_in = (bl_ff == 4'd0) ? S_SQZ : S_EMIT;
                  end
                  crcsr_pkg::OP_LOAD: begin
                     in_we = 1'b1;
                  end
                  crcsr_pkg::OP_RESTORE: begin
                     state_in = S_COPY;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_MERGE: begin
            sp_raddr = {cnt_ff[4:0], 1'b0};
            if (pend_ff) begin
               sp_we    = 1'b1;
               sp_wdata = sp_rdata_ff ^ ((sp_rdata_ff ^ block_ff)
                                         & crcsr_pkg::diag_mask(paddr_ff));
            end
            if (!cnt_ff[5]) begin
               pend_in  = 1'b1;
               paddr_in = {cnt_ff[4:0], 1'b0};
               cnt_in   = cnt_ff + 7'd1;
            end else begin
               cnt_in    = 7'd0;
               rounds_in = abs_rnd_ff;
               state_in  = (abs_rnd_ff == 8'd0) ? S_IDLE : S_RCRC;
            end
         end
         S_SQZ: begin
            sp_raddr = {cnt_ff[4:0], 1'b1};
            diag_in  = diag_nx;
            if (!cnt_ff[5]) begin
               pend_in  = 1'b1;
               paddr_in = {cnt_ff[4:0], 1'b1};
               cnt_in   = cnt_ff + 7'd1;
            end else begin
               cnt_in    = 7'd0;
               buf_in    = diag_nx;
               bl_in     = 4'd8;
               rounds_in = sqz_rnd_ff;
               state_in  = (sqz_rnd_ff == 8'd0) ? S_EMIT : S_RCRC;
            end
         end
         S_RCRC: begin
            if (pend_ff) begin
               crc_ctl.step  = 1'b1;
               xp_ctl.rec_en = 1'b1;
            end
            if (!cnt_ff[6]) begin
               pend_in  = 1'b1;
               paddr_in = cnt_ff[5:0];
               cnt_in   = cnt_ff + 7'd1;
            end else begin
               cnt_in   = 7'd0;
               state_in = S_RXPOSE;
            end
         end
         S_RXPOSE: begin
            sp_we        = 1'b1;
            sp_waddr     = cnt_ff[5:0];
            sp_wdata     = xword;
            xp_ctl.shift = 1'b1;
            cnt_in       = cnt_ff + 7'd1;
            if (cnt_ff[5:0] == 6'd63) begin
               cnt_in    = 7'd0;
               rounds_in = rounds_ff - 8'd1;
               state_in  = (rounds_ff == 8'd1) ? finish : S_RCRC;
            end
         end
         S_COPY: begin
            if (pend_ff) begin
               sp_we    = 1'b1;
               sp_wdata = in_rdata_ff;
            end
            if (!cnt_ff[6]) begin
               pend_in  = 1'b1;
               paddr_in = cnt_ff[5:0];
               cnt_in   = cnt_ff + 7'd1;
            end else begin
               cnt_in   = 7'd0;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = buf_ff[8*bsel +: 8];
               bl_in        = bl_ff - 4'd1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sponge_mem[sp_waddr] <= sp_wdata;
      end
      sp_rdata_ff <= sponge_mem[sp_raddr];
   end

   always_ff @(posedge clock) begin
      if (in_we) begin
         init_mem[f_idx] <= f_data;
      end
      in_rdata_ff <= init_mem[in_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 7'd0;
         pend_ff      <= 1'b0;
         rounds_ff    <= 8'd0;
         sq_ff        <= 1'b0;
         buf_ff       <= 64'h0;
         bl_ff        <= 4'd0;
         rsp_valid_ff <= 1'b0;
         xor_out_ff   <= crcsr_pkg::XOR_OUT_RESET;
         abs_rnd_ff   <= crcsr_pkg::ABS_RND_RESET;
         sqz_rnd_ff   <= crcsr_pkg::SQZ_RND_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rounds_ff    <= rounds_in;
         sq_ff        <= sq_in;
         buf_ff       <= buf_in;
         bl_ff        <= bl_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_fire && (csr_index == crcsr_pkg::REG_XOR_OUT)) begin
            xor_out_ff <= csr_wdata;
         end
         if (csr_fire && (csr_index == crcsr_pkg::REG_ABS_RND)) begin
            abs_rnd_ff <= csr_wdata[7:0];
         end
         if (csr_fire && (csr_index == crcsr_pkg::REG_SQZ_RND)) begin
            sqz_rnd_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      paddr_ff    <= paddr_in;
      block_ff    <= block_in;
      diag_ff     <= diag_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> bench/crc64_sponge_rng_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc64_sponge_rng_tb
// Drives load, restore, absorb, padded final absorb, byte read and unused-code
// requests through the sponge generator under several register settings. A model of
// the sponge state predicts every random byte, and each returned byte is
// checked in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module crc64_sponge_rng_tb;

   localparam logic [2:0] OP_SPARE_5 = 3'd5;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int         STALL_LIMIT = 150000;

   // Tracks the sponge state and queues the bytes that reads must return.
   class sponge_scoreboard;
      logic [63:0] poly, init_crc, xor_mask, crc, sqz_buf;
      logic [7:0]  abs_rounds, sqz_rounds;
      logic [63:0] sponge[64];
      logic [63:0] seed_words[64];
      logic [63:0] records[64];
      logic [63:0] byte_table[256];
      int          bytes_left;
      int          errors;
      logic [7:0]  pending_bytes[$];

      function void build_table();
         logic [63:0] t;
         for (int v = 0; v < 256; v++) begin
            t = {v[7:0], 56'h0};
            for (int b = 0; b < 8; b++)
               t = t[63] ? ({t[62:0], 1'b0} ^ poly) : {t[62:0], 1'b0};
            byte_table[v] = t;
         end
      endfunction

      function void clear();
         poly = crcsr_pkg::POLY_RESET;
         init_crc = crcsr_pkg::INIT_CRC_RESET;
         xor_mask = crcsr_pkg::XOR_OUT_RESET;
         abs_rounds = crcsr_pkg::ABS_RND_RESET;
         sqz_rounds = crcsr_pkg::SQZ_RND_RESET;
         crc = init_crc;
         sqz_buf = 64'h0;
         bytes_left = 0;
         errors = 0;
         for (int i = 0; i < 64; i++) begin
            seed_words[i] = 64'h0;
            sponge[i] = 64'h0;
         end
         build_table();
      endfunction

      function void configure(logic [2:0] idx, logic [63:0] value);
         case (idx)
            crcsr_pkg::REG_POLY: begin
               poly = value;
               build_table();
            end
            crcsr_pkg::REG_INIT: begin
               init_crc = value;
               crc = value;
            end
            crcsr_pkg::REG_XOR_OUT: xor_mask = value;
            crcsr_pkg::REG_ABS_RND: abs_rounds = value[7:0];
            crcsr_pkg::REG_SQZ_RND: sqz_rounds = value[7:0];
            default: ;
         endcase
      endfunction

      function void mix(logic [7:0] rounds);
         logic [63:0] w;
         for (int r = 0; r < rounds; r++) begin
            for (int j = 0; j < 64; j++) begin
               w = sponge[j];
               for (int k = 0; k < 8; k++)
                  crc = byte_table[crc[7:0] ^ w[8*k +: 8]] ^ (crc >> 8);
               records[j] = crc ^ xor_mask;
            end
            for (int j = 0; j < 64; j++)
               for (int i = 0; i < 64; i++)
                  sponge[j][63-i] = records[i][63-j];
         end
      endfunction

      function void absorb(logic [63:0] blk);
         logic [63:0] m;
         for (int i = 0; i < 64; i += 2) begin
            m = (64'h8000000000000000 >> i) | (64'h1 << i);
            sponge[i] = (sponge[i] & ~m) | (blk & m);
         end
         mix(abs_rounds);
      endfunction

      function void note_request(logic [2:0] op, logic [63:0] data,
                                 logic [2:0] cnt, logic [5:0] idx);
         logic [63:0] chunk, blk;
         case (op)
            crcsr_pkg::OP_ABSORB: absorb(data);
            crcsr_pkg::OP_FINAL: begin
               chunk = (cnt == 0) ? 64'h0 : data & (~64'h0 >> (64 - 8 * cnt));
               blk = (chunk << 8) | 64'h80;
               if (cnt < 7) blk = blk << (8 * (7 - cnt));
               absorb(blk | 64'h1);
            end
            crcsr_pkg::OP_READ: begin
               if (bytes_left == 0) begin
                  sqz_buf = 64'h0;
                  for (int i = 1; i < 64; i += 2)
                     sqz_buf |= sponge[i] & ((64'h8000000000000000 >> i) | (64'h1 << i));
                  mix(sqz_rounds);
                  bytes_left = 8;
               end
               bytes_left--;
               pending_bytes.push_back(sqz_buf[8*(7-bytes_left) +: 8]);
            end
            crcsr_pkg::OP_LOAD: seed_words[idx] = data;
            crcsr_pkg::OP_RESTORE: for (int i = 0; i < 64; i++) sponge[i] = seed_words[i];
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_byte(logic [7:0] got);
         logic [7:0] want;
         if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h", got));
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want)
               report($sformatf("random_byte %02h, expected %02h", got, want));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;  // block_data[63:0], byte_count[66:64], word_index[72:67]
   logic [2:0]  req_tuser = '0;  // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // random_byte[7:0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   sponge_scoreboard sb;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold = 0;
   int stall_count = 0;

   crc64_sponge_rng u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_tready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         stall_count = 0;
      end else begin
         stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("crc64_sponge_rng regression: fail");
            $finish;
         end
      end
   end

   task send_request(logic [2:0] op, logic [63:0] data, logic [2:0] cnt, logic [5:0] idx);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'h0, idx, cnt, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, data, cnt, idx);
   endtask

   task end_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Waits for all bytes, then for any absorb still working.
   task drain();
      end_requests();
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (34 + 131 * ((sb.abs_rounds > sb.sqz_rounds) ? sb.abs_rounds : sb.sqz_rounds)
              + 100) @(posedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.configure(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task random_requests(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 30)
            send_request(crcsr_pkg::OP_ABSORB, rand64(), 3'($urandom), 6'($urandom));
         else if (pick < 42)
            send_request(crcsr_pkg::OP_FINAL, rand64(), 3'($urandom), 6'($urandom));
         else if (pick < 85)
            send_request(crcsr_pkg::OP_READ, rand64(), 3'($urandom), 6'($urandom));
         else if (pick < 93)
            send_request(crcsr_pkg::OP_LOAD, rand64(), 3'($urandom), 6'($urandom));
         else if (pick < 97)
            send_request(crcsr_pkg::OP_RESTORE, rand64(), 3'($urandom), 6'($urandom));
         else
            send_request(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)),
                         rand64(), 3'($urandom), 6'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every initial word is written before the first restore.
      for (int i = 0; i < 64; i++) send_request(crcsr_pkg::OP_LOAD, rand64(), 3'd0, 6'(i));
      send_request(crcsr_pkg::OP_RESTORE, 64'h0, 3'd0, 6'd0);
      send_request(crcsr_pkg::OP_ABSORB, 64'h0, 3'd0, 6'd0);
      send_request(crcsr_pkg::OP_ABSORB, ~64'h0, 3'd7, 6'd63);
      for (int c = 0; c < 8; c++) send_request(crcsr_pkg::OP_FINAL, ~64'h0, 3'(c), 6'd0);
      send_request(crcsr_pkg::OP_FINAL, rand64(), 3'd3, 6'd0);
      for (int i = 0; i < 9; i++) send_request(crcsr_pkg::OP_READ, 64'h0, 3'd0, 6'd0);
      send_request(OP_SPARE_5, rand64(), 3'd1, 6'd1);
      send_request(OP_SPARE_6, rand64(), 3'd2, 6'd2);
      send_request(OP_SPARE_7, rand64(), 3'd4, 6'd4);
      send_request(crcsr_pkg::OP_LOAD, ~64'h0, 3'd7, 6'd63);
      send_request(crcsr_pkg::OP_RESTORE, 64'h0, 3'd0, 6'd0);
      send_request(crcsr_pkg::OP_READ, 64'h0, 3'd0, 6'd0);
      drain();

      write_reg(crcsr_pkg::REG_POLY, rand64());
      write_reg(crcsr_pkg::REG_INIT, rand64());
      write_reg(crcsr_pkg::REG_XOR_OUT, rand64());
      write_reg(crcsr_pkg::REG_ABS_RND, 64'd1);
      write_reg(crcsr_pkg::REG_SQZ_RND, 64'd1);
      tx_idle_pct = 22;
      rx_idle_pct = 76;
      // A long receiver stall while reads keep coming fills the block.
      rx_hold = 500;
      for (int i = 0; i < 20; i++) send_request(crcsr_pkg::OP_READ, rand64(), 3'd0, 6'd0);
      random_requests(300);
      drain();

      write_reg(crcsr_pkg::REG_POLY, 64'h0);
      write_reg(crcsr_pkg::REG_INIT, 64'h0);
      write_reg(crcsr_pkg::REG_XOR_OUT, 64'h0);
      write_reg(crcsr_pkg::REG_ABS_RND, 64'd0);
      write_reg(crcsr_pkg::REG_SQZ_RND, 64'd0);
      tx_idle_pct = 76;
      rx_idle_pct = 22;
      random_requests(300);
      drain();

      write_reg(crcsr_pkg::REG_POLY, ~64'h0);
      write_reg(crcsr_pkg::REG_INIT, ~64'h0);
      write_reg(crcsr_pkg::REG_XOR_OUT, rand64());
      write_reg(crcsr_pkg::REG_ABS_RND, 64'd2);
      write_reg(crcsr_pkg::REG_SQZ_RND, 64'd1);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_requests(350);
      drain();

      write_reg(crcsr_pkg::REG_ABS_RND, 64'd255);
      write_reg(crcsr_pkg::REG_SQZ_RND, 64'd255);
      send_request(crcsr_pkg::OP_ABSORB, rand64(), 3'd0, 6'd0);
      for (int i = 0; i < 9; i++) send_request(crcsr_pkg::OP_READ, 64'h0, 3'd0, 6'd0);
      drain();

      if (sb.errors == 0) $display("crc64_sponge_rng regression: pass");
      else $display("crc64_sponge_rng regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/crcsr_pkg.sv
hw/rtl/crcsr_crc.sv
hw/rtl/crcsr_xpose.sv
hw/rtl/crc64_sponge_rng.sv
bench/crc64_sponge_rng_tb.sv
